>>> rtl/core/cpu_control_flow_unit_macros.svh
// Assertion macros shared by the control-flow unit RTL.
`ifndef CPU_CONTROL_FLOW_UNIT_MACROS_SVH
`define CPU_CONTROL_FLOW_UNIT_MACROS_SVH

// Checks an expression at every rising clock edge outside reset.
`define CCFU_ASSERT_ALWAYS(label, clk_i, rst_i, expr) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (expr)) \
    else $error("assertion failed: label");

// Checks that an antecedent implies a consequent in the same cycle.
`define CCFU_ASSERT_IMPLY(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("assertion failed: label");

`endif

>>> rtl/core/ccfu_pkg.sv
// Types and constants of the control-flow unit.
`default_nettype none
package ccfu_pkg;

  // Instruction selector codes.
  localparam logic [4:0] K_BCC     = 5'd0;
  localparam logic [4:0] K_BCS     = 5'd1;
  localparam logic [4:0] K_BNE     = 5'd2;
  localparam logic [4:0] K_BEQ     = 5'd3;
  localparam logic [4:0] K_BPL     = 5'd4;
  localparam logic [4:0] K_BMI     = 5'd5;
  localparam logic [4:0] K_BVC     = 5'd6;
  localparam logic [4:0] K_BVS     = 5'd7;
  localparam logic [4:0] K_BRA     = 5'd8;
  localparam logic [4:0] K_BRL     = 5'd9;
  localparam logic [4:0] K_JMP_ABS = 5'd10;
  localparam logic [4:0] K_JMP_LNG = 5'd11;
  localparam logic [4:0] K_JMP_IND = 5'd12;
  localparam logic [4:0] K_JMP_IDX = 5'd13;
  localparam logic [4:0] K_JMP_ILG = 5'd14;
  localparam logic [4:0] K_JSR_ABS = 5'd15;
  localparam logic [4:0] K_JSR_LNG = 5'd16;
  localparam logic [4:0] K_JSR_IDX = 5'd17;
  localparam logic [4:0] K_RTI     = 5'd18;
  localparam logic [4:0] K_RTS     = 5'd19;
  localparam logic [4:0] K_RTL     = 5'd20;

  // Branch condition groups, selected by kind bits 2 and 1.
  localparam logic [1:0] COND_CARRY = 2'd0;
  localparam logic [1:0] COND_ZERO  = 2'd1;
  localparam logic [1:0] COND_NEG   = 2'd2;
  localparam logic [1:0] COND_OVF   = 2'd3;

  // Status bits forced in emulation mode on return from interrupt.
  localparam logic [7:0] EMU_FLAG_FORCE = 8'h30;

  // Bit positions in the status register.
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_X = 4;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  // Push byte counts.
  localparam logic [1:0] PUSH_NONE  = 2'd0;
  localparam logic [1:0] PUSH_SHORT = 2'd2;
  localparam logic [1:0] PUSH_LONG  = 2'd3;

  // One instruction request.
  typedef struct packed {
    logic [4:0]  kind;
    logic [23:0] pc;
    logic [23:0] operand;
    logic [7:0]  flags;
    logic [15:0] index_x;
    logic        emulation;
    logic [23:0] pointer_data;
    logic [31:0] stack_data;
  } req_t;

  // One result.
  typedef struct packed {
    logic [23:0] new_pc;
    logic        taken;
    logic [23:0] pointer_address;
    logic [1:0]  push_count;
    logic [23:0] push_data;
    logic [7:0]  new_flags;
    logic        flags_written;
    logic        clear_index_high;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/core/ccfu_in_stage.sv
// Input register stage: captures an accepted request and its valid bit.
`default_nettype none
module ccfu_in_stage
  import ccfu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire req_t req_in,
  output logic      req_valid,
  output req_t      req
);

  // Valid bit is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= accept;
    end
  end

  // Payload is loaded on every accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= req_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ccfu_next_pc.sv
// Combinational next program counter, push and status restore logic.
`default_nettype none
module ccfu_next_pc
  import ccfu_pkg::*;
(
  input  wire req_t req,
  output res_t      res
);

  logic [7:0]  bank;
  logic [15:0] ret;
  logic [15:0] off16;
  logic [15:0] idx_addr;
  logic [15:0] stk_inc;
  logic        flag_bit;
  logic        cond;
  logic [7:0]  rti_flags;

  // Shared address terms; all 16-bit sums wrap inside the bank.
  assign bank     = req.pc[23:16];
  assign ret      = req.pc[15:0] - 16'd1;
  assign off16    = {{8{req.operand[7]}}, req.operand[7:0]};
  assign idx_addr = req.operand[15:0] + req.index_x;
  assign stk_inc  = req.stack_data[15:0] + 16'd1;

  // Flag tested by the conditional branches.
  always_comb begin
    case (req.kind[2:1])
      COND_CARRY: flag_bit = req.flags[FLAG_C];
      COND_ZERO:  flag_bit = req.flags[FLAG_Z];
      COND_NEG:   flag_bit = req.flags[FLAG_N];
      COND_OVF:   flag_bit = req.flags[FLAG_V];
      default:    flag_bit = req.flags[FLAG_V];
    endcase
  end

  // Odd kinds branch on a set flag, even kinds on a clear flag.
  assign cond = req.kind[0] ? flag_bit : ~flag_bit;

  assign rti_flags = req.stack_data[7:0] | (req.emulation ? EMU_FLAG_FORCE : 8'h00);

  // Result selection by instruction kind.
  always_comb begin
    res = '0;
    res.new_pc = req.pc;
    case (req.kind)
      K_BCC, K_BCS, K_BNE, K_BEQ, K_BPL, K_BMI, K_BVC, K_BVS: begin
        if (cond) begin
          res.new_pc = {bank, req.pc[15:0] + off16};
          res.taken  = 1'b1;
        end
      end
      K_BRA: begin
        res.new_pc = {bank, req.pc[15:0] + off16};
        res.taken  = 1'b1;
      end
      K_BRL: begin
        res.new_pc = {bank, req.pc[15:0] + req.operand[15:0]};
        res.taken  = 1'b1;
      end
      K_JMP_ABS: begin
        res.new_pc = {bank, req.operand[15:0]};
        res.taken  = 1'b1;
      end
      K_JMP_LNG: begin
        res.new_pc = req.operand;
        res.taken  = 1'b1;
      end
      K_JMP_IND: begin
        res.pointer_address = {8'h00, req.operand[15:0]};
        res.new_pc = {bank, req.pointer_data[15:0]};
        res.taken  = 1'b1;
      end
      K_JMP_IDX: begin
        res.pointer_address = {bank, idx_addr};
        res.new_pc = {bank, req.pointer_data[15:0]};
        res.taken  = 1'b1;
      end
      K_JMP_ILG: begin
        res.pointer_address = {8'h00, req.operand[15:0]};
        res.new_pc = req.pointer_data;
        res.taken  = 1'b1;
      end
      K_JSR_ABS: begin
        res.push_count = PUSH_SHORT;
        res.push_data  = {8'h00, ret[7:0], ret[15:8]};
        res.new_pc = {bank, req.operand[15:0]};
        res.taken  = 1'b1;
      end
      K_JSR_LNG: begin
        res.push_count = PUSH_LONG;
        res.push_data  = {ret[7:0], ret[15:8], bank};
        res.new_pc = req.operand;
        res.taken  = 1'b1;
      end
      K_JSR_IDX: begin
        res.push_count = PUSH_SHORT;
        res.push_data  = {8'h00, ret[7:0], ret[15:8]};
        res.pointer_address = {bank, idx_addr};
        res.new_pc = {bank, req.pointer_data[15:0]};
        res.taken  = 1'b1;
      end
      K_RTI: begin
        res.new_flags        = rti_flags;
        res.flags_written    = 1'b1;
        res.clear_index_high = rti_flags[FLAG_X];
        res.new_pc = req.emulation ? {bank, req.stack_data[23:8]} : req.stack_data[31:8];
        res.taken  = 1'b1;
      end
      K_RTS: begin
        res.new_pc = {bank, stk_inc};
        res.taken  = 1'b1;
      end
      K_RTL: begin
        res.new_pc = {req.stack_data[23:16], stk_inc};
        res.taken  = 1'b1;
      end
      default: begin
        // Unknown kinds leave the program counter unchanged.
        res.new_pc = req.pc;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/cpu_control_flow_unit.sv
// Top level of the control-flow unit: input stage, next-PC logic, result register.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------------------
//   request  | start / busy     | instruction kind, PC, operand, flags, X, pointers, stack
//   result   | done (one cycle) | next PC, taken, pointer address, pushes, status restore
//
// A request is taken in every cycle in which start is high; busy is high only during reset.
// Each result passes the input register and then the result register around the
// next-PC logic before it reaches the ports, where done marks it.
// Reset is synchronous and clears both valid bits; requests in flight are dropped.
// The receiver cannot stall, so done is a one-cycle strobe per request.
`default_nettype none
`include "cpu_control_flow_unit_macros.svh"
module cpu_control_flow_unit
  import ccfu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [4:0]  kind,
  input  wire logic [23:0] pc,
  input  wire logic [23:0] operand,
  input  wire logic [7:0]  flags,
  input  wire logic [15:0] index_x,
  input  wire logic        emulation,
  input  wire logic [23:0] pointer_data,
  input  wire logic [31:0] stack_data,
  output logic             done,
  output logic [23:0]      new_pc,
  output logic             taken,
  output logic [23:0]      pointer_address,
  output logic [1:0]       push_count,
  output logic [23:0]      push_data,
  output logic [7:0]       new_flags,
  output logic             flags_written,
  output logic             clear_index_high
);

  req_t req_in;
  req_t req;
  logic req_valid;
  res_t res_comb;
  res_t res;
  logic no_push;
  logic no_ptr;
  logic no_status;

  assign busy = rst;

  assign req_in = '{kind: kind, pc: pc, operand: operand, flags: flags,
                    index_x: index_x, emulation: emulation,
                    pointer_data: pointer_data, stack_data: stack_data};

  // Request register.
  ccfu_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .accept    (start && !busy),
    .req_in    (req_in),
    .req_valid (req_valid),
    .req       (req)
  );

  // Next program counter logic.
  ccfu_next_pc u_next_pc (
    .req (req),
    .res (res_comb)
  );

  // Result strobe register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (req_valid) begin
      res <= res_comb;
    end
  end

  assign new_pc           = res.new_pc;
  assign taken            = res.taken;
  assign pointer_address  = res.pointer_address;
  assign push_count       = res.push_count;
  assign push_data        = res.push_data;
  assign new_flags        = res.new_flags;
  assign flags_written    = res.flags_written;
  assign clear_index_high = res.clear_index_high;

  // Side-effect terms used by the checks below.
  assign no_push   = (push_count == PUSH_NONE);
  assign no_ptr    = (pointer_address == 24'h0);
  assign no_status = !flags_written && !clear_index_high;

  // Every captured request yields exactly one strobe in the next cycle.
  `CCFU_ASSERT_ALWAYS(a_done_follows_req, clk, rst, done == $past(req_valid))
  // A status restore never comes with pushes or a pointer read.
  `CCFU_ASSERT_IMPLY(a_rti_clean, clk, rst, done && flags_written, taken && no_push && no_ptr)
  // An untaken result has no pushes and no status restore.
  `CCFU_ASSERT_IMPLY(a_untaken_quiet, clk, rst, done && !taken, no_push && no_status)

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the control-flow unit: directed and random instruction requests.
module testbench
  import ccfu_pkg::*;
;

  // First and last selector codes that the unit treats as a no-op.
  localparam logic [4:0] KIND_NOOP_FIRST = K_RTL + 5'd1;
  localparam logic [4:0] KIND_TOP        = 5'h1f;

  localparam int DIRECTED_ITEMS = 24;
  localparam int RANDOM_ITEMS   = 900;
  // Requests from QUIET_FIRST up to but not including QUIET_LAST are sent back to back with no gaps.
  localparam int QUIET_FIRST    = 200;
  localparam int QUIET_LAST     = 450;
  // Before this request the sender waits until every result is back.
  localparam int DRAIN_AT       = 600;
  localparam int TAIL_CYCLES    = 8;
  localparam int CYCLE_LIMIT    = 100000;

  // Holds the expected results of accepted requests in order and checks outputs.
  class flow_scoreboard;
    res_t expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Works out the next program counter and side outputs of one instruction.
    function res_t next_flow(req_t r);
      res_t o;
      logic [7:0] bank;
      logic [15:0] ret;
      logic [15:0] offset;
      logic [15:0] target;
      logic [7:0] restored;
      logic cond_bit;
      o = '0;
      o.new_pc = r.pc;
      bank = r.pc[23:16];
      ret = r.pc[15:0] - 16'd1;
      cond_bit = 1'b0;
      if (r.kind <= K_BRA) begin
        // Flag branches test one status bit; even codes branch on clear.
        case (r.kind[2:1])
          COND_CARRY: cond_bit = r.flags[FLAG_C];
          COND_ZERO:  cond_bit = r.flags[FLAG_Z];
          COND_NEG:   cond_bit = r.flags[FLAG_N];
          default:    cond_bit = r.flags[FLAG_V];
        endcase
        if (r.kind == K_BRA || (r.kind[0] ? cond_bit : !cond_bit)) begin
          offset = {{8{r.operand[7]}}, r.operand[7:0]};
          target = r.pc[15:0] + offset;
          o.new_pc = {bank, target};
          o.taken = 1'b1;
        end
      end else if (r.kind <= K_RTL) begin
        o.taken = 1'b1;
        case (r.kind)
          K_BRL: begin
            target = r.pc[15:0] + r.operand[15:0];
            o.new_pc = {bank, target};
          end
          K_JMP_ABS: o.new_pc = {bank, r.operand[15:0]};
          K_JMP_LNG: o.new_pc = r.operand;
          K_JMP_IND: begin
            o.pointer_address = {8'h00, r.operand[15:0]};
            o.new_pc = {bank, r.pointer_data[15:0]};
          end
          K_JMP_IDX: begin
            target = r.operand[15:0] + r.index_x;
            o.pointer_address = {bank, target};
            o.new_pc = {bank, r.pointer_data[15:0]};
          end
          K_JMP_ILG: begin
            o.pointer_address = {8'h00, r.operand[15:0]};
            o.new_pc = r.pointer_data;
          end
          K_JSR_ABS: begin
            o.push_count = PUSH_SHORT;
            o.push_data = {8'h00, ret[7:0], ret[15:8]};
            o.new_pc = {bank, r.operand[15:0]};
          end
          K_JSR_LNG: begin
            o.push_count = PUSH_LONG;
            o.push_data = {ret[7:0], ret[15:8], bank};
            o.new_pc = r.operand;
          end
          K_JSR_IDX: begin
            o.push_count = PUSH_SHORT;
            o.push_data = {8'h00, ret[7:0], ret[15:8]};
            target = r.operand[15:0] + r.index_x;
            o.pointer_address = {bank, target};
            o.new_pc = {bank, r.pointer_data[15:0]};
          end
          K_RTI: begin
            // Emulation mode forces bits 4 and 5 and keeps the program bank.
            restored = r.stack_data[7:0];
            if (r.emulation) restored = restored | EMU_FLAG_FORCE;
            o.new_flags = restored;
            o.flags_written = 1'b1;
            o.clear_index_high = restored[FLAG_X];
            if (r.emulation) o.new_pc = {bank, r.stack_data[23:8]};
            else o.new_pc = r.stack_data[31:8];
          end
          K_RTS: begin
            target = r.stack_data[15:0] + 16'd1;
            o.new_pc = {bank, target};
          end
          default: begin
            target = r.stack_data[15:0] + 16'd1;
            o.new_pc = {r.stack_data[23:16], target};
          end
        endcase
      end
      return o;
    endfunction

    function void note_request(req_t r);
      expected_q.push_back(next_flow(r));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request waiting: new_pc %0h", got.new_pc);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("new_pc", 32'(want.new_pc), 32'(got.new_pc));
      compare_field("taken", 32'(want.taken), 32'(got.taken));
      compare_field("pointer_address", 32'(want.pointer_address),
                    32'(got.pointer_address));
      compare_field("push_count", 32'(want.push_count), 32'(got.push_count));
      compare_field("push_data", 32'(want.push_data), 32'(got.push_data));
      compare_field("new_flags", 32'(want.new_flags), 32'(got.new_flags));
      compare_field("flags_written", 32'(want.flags_written), 32'(got.flags_written));
      compare_field("clear_index_high", 32'(want.clear_index_high),
                    32'(got.clear_index_high));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        drive_req;
  logic        done;
  logic [23:0] new_pc;
  logic        taken;
  logic [23:0] pointer_address;
  logic [1:0]  push_count;
  logic [23:0] push_data;
  logic [7:0]  new_flags;
  logic        flags_written;
  logic        clear_index_high;
  res_t        seen_res;
  int unsigned cycle_count = 0;
  flow_scoreboard board;

  assign seen_res = {new_pc, taken, pointer_address, push_count, push_data,
                     new_flags, flags_written, clear_index_high};

  cpu_control_flow_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .kind             (drive_req.kind),
    .pc               (drive_req.pc),
    .operand          (drive_req.operand),
    .flags            (drive_req.flags),
    .index_x          (drive_req.index_x),
    .emulation        (drive_req.emulation),
    .pointer_data     (drive_req.pointer_data),
    .stack_data       (drive_req.stack_data),
    .done             (done),
    .new_pc           (new_pc),
    .taken            (taken),
    .pointer_address  (pointer_address),
    .push_count       (push_count),
    .push_data        (push_data),
    .new_flags        (new_flags),
    .flags_written    (flags_written),
    .clear_index_high (clear_index_high)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Results are checked and accepted requests noted at each rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_result(seen_res);
      if (start && !busy) board.note_request(drive_req);
    end
  end

  // Ends a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cpu_control_flow_unit test failed");
      $finish;
    end
  end

  // Drives one request from a falling edge and returns at the falling edge after it is taken.
  task automatic send_request(input req_t r, input bit allow_gap);
    int unsigned gap;
    bit was_busy;
    gap = 0;
    // Each idle cycle is added with a chance of about one in nine.
    while (allow_gap && $urandom_range(0, 99) < 11) gap++;
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    drive_req = r;
    start = 1'b1;
    // Busy follows reset, which does not move while requests are sent, so its value here holds for the next edge.
    do begin
      was_busy = busy;
      @(negedge clk);
    end while (was_busy);
  endtask

  initial begin
    req_t r;
    int i;
    bit ext;
    rst = 1'b1;
    start = 1'b0;
    drive_req = '0;
    board = new();
    repeat (12) @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    // Directed part: every instruction with all-zero fields (operand 80h) and all-one fields in turn,
    // return from interrupt in emulation mode, and selector codes past the last one.
    for (i = 0; i < DIRECTED_ITEMS; i++) begin
      ext = i[0];
      r.pc = ext ? 24'hffffff : 24'h000000;
      r.operand = ext ? 24'hffffff : 24'h000080;
      r.flags = ext ? 8'hff : 8'h00;
      r.index_x = ext ? 16'hffff : 16'h0000;
      r.emulation = ext;
      r.pointer_data = ext ? 24'hffffff : 24'h000000;
      r.stack_data = ext ? 32'hffffffff : 32'h00000000;
      if (i <= int'(K_RTL)) r.kind = 5'(i);
      else if (i == int'(K_RTL) + 1) begin
        r.kind = K_RTI;
        r.emulation = 1'b1;
        r.stack_data = 32'h00000000;
      end else if (i == int'(K_RTL) + 2) r.kind = KIND_NOOP_FIRST;
      else r.kind = KIND_TOP;
      // Flags of zero make even branches taken and odd ones fall through.
      if (r.kind < K_BRA) r.flags = 8'h00;
      send_request(r, 1'b1);
    end

    // Random part with wrap-prone program counters and branch offsets.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 5) r.kind = 5'($urandom_range(KIND_NOOP_FIRST, KIND_TOP));
      else r.kind = 5'($urandom_range(0, K_RTL));
      r.pc = 24'($urandom);
      r.operand = 24'($urandom);
      r.flags = 8'($urandom);
      r.index_x = 16'($urandom);
      r.emulation = 1'($urandom);
      r.pointer_data = 24'($urandom);
      r.stack_data = $urandom;
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: r.pc[15:0] = 16'h0000;
          1: r.pc[15:0] = 16'h0001;
          2: r.pc[15:0] = 16'hfffe;
          default: r.pc[15:0] = 16'hffff;
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: r.operand[7:0] = 8'h7f;
          1: r.operand[7:0] = 8'h80;
          2: r.operand[7:0] = 8'h00;
          default: r.operand[7:0] = 8'hff;
        endcase
      end
      if (i == DRAIN_AT) begin
        start = 1'b0;
        while (board.pending() != 0) @(negedge clk);
      end
      send_request(r, !(i >= QUIET_FIRST && i < QUIET_LAST));
    end
    start = 1'b0;

    // Drain the pipeline, then keep watching for stray results.
    while (board.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("cpu_control_flow_unit test passed");
    end else begin
      $display("cpu_control_flow_unit test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ccfu_pkg.sv
rtl/core/ccfu_in_stage.sv
rtl/core/ccfu_next_pc.sv
rtl/core/cpu_control_flow_unit.sv
dv/testbench.sv
